>>> design/dda_pkg.sv
// ---------------------------------------------------------------------------
// dda_pkg: shared types and constants for the DDA line rasteriser
// Coordinate and fixed-point widths, the transaction payloads, the sequencer
// states and the request/response bundles of the shared divider.
// ---------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int POS_BITS   = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_BITS  = FRAC_BITS + 2;
  localparam int REM_BITS   = COORD_BITS + 1;
  localparam int NUM_BITS   = COORD_BITS + FRAC_BITS;
  localparam int CNT_BITS   = $clog2(NUM_BITS);

  // One half in the position format, added before truncation to round half up.
  localparam logic [POS_BITS-1:0] HALF_LSB = POS_BITS'(1) << (FRAC_BITS - 1);

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } state_t;

  typedef struct packed {
    func_t                         func;
    logic signed [COORD_BITS-1:0]  x_start;
    logic signed [COORD_BITS-1:0]  y_start;
    logic signed [COORD_BITS-1:0]  x_end;
    logic signed [COORD_BITS-1:0]  y_end;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic                          last;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [NUM_BITS-1:0]  num;
    logic [REM_BITS-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [NUM_BITS-1:0]  quot;
    logic [REM_BITS-1:0]  rem;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> design/dda_div.sv
// ---------------------------------------------------------------------------
// dda_div: iterative unsigned restoring divider
// Produces one quotient bit per cycle; the quotient and remainder are valid
// in the cycle in which done is high.
// ---------------------------------------------------------------------------
`default_nettype none

module dda_div import dda_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [NUM_BITS-1:0] quot_r, quot_nxt;
  logic [REM_BITS-1:0] rem_r, rem_nxt;
  logic [REM_BITS-1:0] den_r, den_nxt;
  logic [REM_BITS:0]   trial;
  logic [REM_BITS:0]   diff;

  always_comb begin
    trial    = {rem_r, quot_r[NUM_BITS-1]};
    diff     = trial - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (busy_r) begin
      // A borrow out of the trial subtraction means this quotient bit is zero.
      quot_nxt = {quot_r[NUM_BITS-2:0], ~diff[REM_BITS]};
      rem_nxt  = diff[REM_BITS] ? trial[REM_BITS-1:0] : diff[REM_BITS-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_BITS'(NUM_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

>>> design/dda_line_rasterizer.sv
// ---------------------------------------------------------------------------
// dda_line_rasterizer: DDA line rasteriser top level
// Loads a pair of endpoints, derives per-step increments with a shared
// divider and then emits one rounded pixel for every step transaction on an active line.
// ---------------------------------------------------------------------------
// Usage:
//   The in_ channel carries load and step transactions; the out_ channel
//   carries pixels. A load produces no pixel; it holds in_ready low while
//   the two increments are computed by one shared restoring divider, one
//   quotient bit per cycle, x first and then y. A zero-length line needs
//   no division and the block is ready again on the next cycle.
//   A step transaction, while a line is active, puts its pixel in the output
//   register on the following cycle; steps can be taken one per cycle as
//   long as the receiver keeps out_ready high. A step with no active line is
//   dropped silently. The line gives max(|dx|,|dy|) pixels, the second
//   endpoint excluded, with last set on the final one.
//   When the receiver stalls, the pixel waits in the output register and
//   in_ready stays low until it has been taken.
//   After reset no line is active and the output register is empty.
// ---------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer import dda_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  state_t                state_r, state_nxt;
  logic [POS_BITS-1:0]   pos_x_r, pos_x_nxt;
  logic [POS_BITS-1:0]   pos_y_r, pos_y_nxt;
  logic [STEP_BITS-1:0]  step_x_r, step_x_nxt;
  logic [STEP_BITS-1:0]  step_y_r, step_y_nxt;
  logic [REM_BITS-1:0]   remaining_r, remaining_nxt;
  logic [REM_BITS-1:0]   len_r, len_nxt;
  logic [REM_BITS-1:0]   abs_dy_r, abs_dy_nxt;
  logic                  neg_x_r, neg_x_nxt;
  logic                  neg_y_r, neg_y_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  in_accept;
  logic                  load_acc;
  logic                  step_acc;
  logic [REM_BITS-1:0]   dx_w, dy_w, adx_w, ady_w, len_w;
  logic [POS_BITS-1:0]   round_x, round_y;
  logic [STEP_BITS-1:0]  quot_s, step_q;
  logic                  quot_neg;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  dda_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_accept = in_valid && in_ready;
  assign load_acc  = in_accept && (in_data.func == FUNC_LOAD);
  assign step_acc  = in_accept && (in_data.func == FUNC_STEP) && (remaining_r != '0);

  // Endpoint differences, their magnitudes and the major-axis length.
  always_comb begin
    dx_w  = {in_data.x_end[COORD_BITS-1], in_data.x_end}
          - {in_data.x_start[COORD_BITS-1], in_data.x_start};
    dy_w  = {in_data.y_end[COORD_BITS-1], in_data.y_end}
          - {in_data.y_start[COORD_BITS-1], in_data.y_start};
    adx_w = dx_w[REM_BITS-1] ? (~dx_w + 1'b1) : dx_w;
    ady_w = dy_w[REM_BITS-1] ? (~dy_w + 1'b1) : dy_w;
    len_w = (ady_w > adx_w) ? ady_w : adx_w;
  end

  // Floor of a signed quotient: for a negative numerator, -q - (r != 0)
  // equals ~q + (r == 0).
  always_comb begin
    quot_neg = (state_r == ST_DIV_X) ? neg_x_r : neg_y_r;
    quot_s   = div_rsp.quot[STEP_BITS-1:0];
    step_q   = quot_neg ? (~quot_s + STEP_BITS'(div_rsp.rem == '0)) : quot_s;
  end

  always_comb begin
    round_x = pos_x_r + HALF_LSB;
    round_y = pos_y_r + HALF_LSB;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (load_acc && (len_w != '0)) state_nxt = ST_DIV_X;
      end
      ST_DIV_X: begin
        if (div_rsp.done) state_nxt = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        if (div_rsp.done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = {adx_w[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
    div_req.den   = len_w;
    case (state_r)
      ST_IDLE: begin
        in_ready      = !out_valid_r || out_ready;
        div_req.start = load_acc && (len_w != '0);
      end
      ST_DIV_X: begin
        div_req.start = div_rsp.done;
        div_req.num   = {abs_dy_r[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
        div_req.den   = len_r;
      end
      ST_DIV_Y: begin
        div_req.start = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Datapath.
  always_comb begin
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    step_x_nxt    = step_x_r;
    step_y_nxt    = step_y_r;
    remaining_nxt = remaining_r;
    len_nxt       = len_r;
    abs_dy_nxt    = abs_dy_r;
    neg_x_nxt     = neg_x_r;
    neg_y_nxt     = neg_y_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (load_acc) begin
      pos_x_nxt     = {in_data.x_start[COORD_BITS-1], in_data.x_start, {FRAC_BITS{1'b0}}};
      pos_y_nxt     = {in_data.y_start[COORD_BITS-1], in_data.y_start, {FRAC_BITS{1'b0}}};
      step_x_nxt    = '0;
      step_y_nxt    = '0;
      remaining_nxt = '0;
      len_nxt       = len_w;
      abs_dy_nxt    = ady_w;
      neg_x_nxt     = dx_w[REM_BITS-1];
      neg_y_nxt     = dy_w[REM_BITS-1];
    end else if (step_acc) begin
      out_valid_nxt        = 1'b1;
      out_data_nxt.pixel_x = round_x[FRAC_BITS +: COORD_BITS];
      out_data_nxt.pixel_y = round_y[FRAC_BITS +: COORD_BITS];
      out_data_nxt.last    = (remaining_r == REM_BITS'(1));
      pos_x_nxt = pos_x_r + {{(POS_BITS-STEP_BITS){step_x_r[STEP_BITS-1]}}, step_x_r};
      pos_y_nxt = pos_y_r + {{(POS_BITS-STEP_BITS){step_y_r[STEP_BITS-1]}}, step_y_r};
      remaining_nxt = remaining_r - 1'b1;
    end

    if (div_rsp.done && (state_r == ST_DIV_X)) begin
      step_x_nxt = step_q;
    end
    if (div_rsp.done && (state_r == ST_DIV_Y)) begin
      step_y_nxt    = step_q;
      remaining_nxt = len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      remaining_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      remaining_r <= remaining_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    step_x_r   <= step_x_nxt;
    step_y_r   <= step_y_nxt;
    len_r      <= len_nxt;
    abs_dy_r   <= abs_dy_nxt;
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A line only becomes active once both increments are in place.
  a_active_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (remaining_r != '0) |-> (state_r == ST_IDLE))
    else $error("line active while the divider sequence is running");

  a_len_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV_Y) && div_rsp.done) |=> (remaining_r == $past(len_r)))
    else $error("pixel count not loaded at the end of the second division");

  a_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
    step_acc |=> (out_valid_r && (remaining_r == $past(remaining_r) - 1'b1)))
    else $error("step transaction on an active line did not produce a pixel");

endmodule

`default_nettype wire
